>>> hdl/rbil_pkg.sv
// rbil_pkg: shared types and constants for the ring buffer indexed list.
// Action codes, sequencer states, field widths and parameter defaults.
// No dependencies.
package rbil_pkg;

   localparam int RBIL_CAPACITY   = 16;
   localparam int RBIL_DATA_WIDTH = 32;

   localparam int ACTION_W = 3;
   localparam int POS_W    = 5;
   localparam int WORD_W   = 32;
   localparam int FILL_W   = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT   = 3'd0,
      ACT_PUSH_BACK    = 3'd1,
      ACT_INSERT_AT    = 3'd2,
      ACT_DELETE_AT    = 3'd3,
      ACT_READ_AT      = 3'd4,
      ACT_DELETE_FIRST = 3'd5,
      ACT_DELETE_LAST  = 3'd6,
      ACT_CLEAR        = 3'd7
   } action_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_START = 5'b00010,
      S_SHIFT = 5'b00100,
      S_LAST  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

endpackage

>>> hdl/rbil_ram.sv
// rbil_ram: generic single write port, single read port RAM.
// Read data is registered. No dependencies.
module rbil_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rbil_slot.sv
// rbil_slot: shared modular address unit, (base + offset) mod CAPACITY.
// Both inputs are below CAPACITY, so one compare and subtract wraps the sum.
// No dependencies.
module rbil_slot #(
   parameter int CAPACITY = 16
) (
   input  logic [$clog2(CAPACITY)-1:0] base,
   input  logic [$clog2(CAPACITY)-1:0] offset,
   output logic [$clog2(CAPACITY)-1:0] slot
);

   localparam int AW = $clog2(CAPACITY);
   localparam logic [AW:0] LIMIT = (AW+1)'(CAPACITY);

   logic [AW:0] sum;
   logic [AW:0] wrapped;

   always_comb begin
      sum     = {1'b0, base} + {1'b0, offset};
      wrapped = (sum >= LIMIT) ? (sum - LIMIT) : sum;
      slot    = wrapped[AW-1:0];
   end

endmodule

>>> hdl/ring_buffer_indexed_list_core.sv
// ring_buffer_indexed_list_core: circular list with indexed insert, delete and read.
// Sequence: accept, S_START, S_SHIFT while entries move (none for push, read and
// delete last), S_LAST, S_RESP; failed requests and clear respond in the next cycle.
// Throughput: one item at a time; entry moves go one per cycle through the RAM port.
// Reset: count, head and sequencer clear; store contents are not cleared.
module ring_buffer_indexed_list_core import rbil_pkg::*; #(
   parameter int CAPACITY   = RBIL_CAPACITY,
   parameter int DATA_WIDTH = RBIL_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [POS_W-1:0]    req_position,
   input  logic [WORD_W-1:0]   req_word_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ok,
   output logic [WORD_W-1:0]   rsp_word_out,
   output logic [FILL_W-1:0]   rsp_fill_count
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int MW   = (CW > POS_W) ? CW : POS_W;
   localparam int IN_W = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
   localparam logic [AW-1:0] STEP_DN = AW'(CAPACITY - 1);
   localparam logic [AW-1:0] STEP_UP = AW'(1);
   localparam logic [CW-1:0] FULL    = CW'(CAPACITY);

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         head_ff, head_in;

   logic                  ok_ff, ins_ff, grab_ff, pf_ff, pair_ff;
   logic [AW-1:0]         l0_ff, addr0_ff, addr1_ff;
   logic [CW-1:0]         left_ff;
   logic [DATA_WIDTH-1:0] word_ff, got_ff;

   logic                  acc_ok, acc_ins, acc_grab, acc_pf, acc_clear, acc_dec;
   logic [AW-1:0]         acc_l0;
   logic [CW-1:0]         acc_left;
   logic [MW-1:0]         pos_m, cnt_m;
   logic                  not_full, not_empty;

   logic [AW-1:0]         unit_base, unit_off, unit_slot;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic                  wr_en;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   // request decode
   always_comb begin
      pos_m     = MW'(req_position);
      cnt_m     = MW'(count_ff);
      not_full  = (count_ff != FULL);
      not_empty = (count_ff != '0);
      acc_ok    = 1'b0;
      acc_ins   = 1'b0;
      acc_grab  = 1'b0;
      acc_pf    = 1'b0;
      acc_clear = 1'b0;
      acc_dec   = 1'b0;
      acc_l0    = '0;
      acc_left  = '0;
      case (action_type'(req_action))
         ACT_PUSH_FRONT: begin
            if (not_full) begin
               acc_ok  = 1'b1;
               acc_ins = 1'b1;
               acc_pf  = 1'b1;
            end
         end
         ACT_PUSH_BACK: begin
            if (not_full) begin
               acc_ok  = 1'b1;
               acc_ins = 1'b1;
               acc_l0  = AW'(count_ff);
            end
         end
         ACT_INSERT_AT: begin
            if (pos_m <= cnt_m && not_full) begin
               acc_ok   = 1'b1;
               acc_ins  = 1'b1;
               acc_l0   = AW'(count_ff);
               acc_left = count_ff - CW'(req_position);
            end
         end
         ACT_DELETE_AT: begin
            if (pos_m < cnt_m) begin
               acc_ok   = 1'b1;
               acc_grab = 1'b1;
               acc_dec  = 1'b1;
               acc_l0   = AW'(req_position);
               acc_left = count_ff - CW'(req_position) - CW'(1);
            end
         end
         ACT_READ_AT: begin
            if (pos_m < cnt_m) begin
               acc_ok   = 1'b1;
               acc_grab = 1'b1;
               acc_l0   = AW'(req_position);
            end
         end
         ACT_DELETE_FIRST: begin
            if (not_empty) begin
               acc_ok   = 1'b1;
               acc_grab = 1'b1;
               acc_dec  = 1'b1;
               acc_left = count_ff - CW'(1);
            end
         end
         ACT_DELETE_LAST: begin
            if (not_empty) begin
               acc_ok   = 1'b1;
               acc_grab = 1'b1;
               acc_dec  = 1'b1;
               acc_l0   = AW'(count_ff - CW'(1));
            end
         end
         ACT_CLEAR: begin
            acc_ok    = 1'b1;
            acc_clear = 1'b1;
         end
         default: begin
            acc_ok = 1'b0;
         end
      endcase
   end

   // shared address unit: start slot, then one step per cycle
   always_comb begin
      if (state_ff == S_START) begin
         unit_base = head_ff;
         unit_off  = pf_ff ? STEP_DN : l0_ff;
      end else begin
         unit_base = addr1_ff;
         unit_off  = ins_ff ? STEP_DN : STEP_UP;
      end
   end

   rbil_slot #(.CAPACITY(CAPACITY)) u_slot (
      .base   (unit_base),
      .offset (unit_off),
      .slot   (unit_slot)
   );

   always_comb begin
      rd_addr = addr1_ff;
      if (state_ff == S_START || (state_ff == S_SHIFT && left_ff != '0)) begin
         rd_addr = unit_slot;
      end
      wr_en   = 1'b0;
      wr_addr = addr0_ff;
      wr_data = rd_data;
      if (state_ff == S_SHIFT && pair_ff) begin
         wr_en = 1'b1;
      end else if (state_ff == S_LAST && ins_ff) begin
         wr_en   = 1'b1;
         wr_addr = addr1_ff;
         wr_data = word_ff;
      end
   end

   rbil_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      head_in  = head_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (acc_ok && !acc_clear) ? S_START : S_RESP;
               if (acc_clear) begin
                  count_in = '0;
                  head_in  = '0;
               end else if (acc_ok && acc_ins) begin
                  count_in = count_ff + CW'(1);
               end else if (acc_dec) begin
                  count_in = count_ff - CW'(1);
               end
            end
         end
         S_START: begin
            state_in = S_SHIFT;
            if (pf_ff) begin
               head_in = unit_slot;
            end
         end
         S_SHIFT: begin
            if (left_ff == '0) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ok_ff   <= acc_ok;
               ins_ff  <= acc_ins;
               grab_ff <= acc_grab;
               pf_ff   <= acc_pf;
               l0_ff   <= acc_l0;
               left_ff <= acc_left;
               word_ff <= DATA_WIDTH'(req_word_in[IN_W-1:0]);
               got_ff  <= '0;
            end
         end
         S_START: begin
            addr1_ff <= unit_slot;
            pair_ff  <= 1'b0;
         end
         S_SHIFT: begin
            if (!pair_ff && grab_ff) begin
               got_ff <= rd_data;
            end
            if (left_ff != '0) begin
               addr0_ff <= addr1_ff;
               addr1_ff <= unit_slot;
               left_ff  <= left_ff - CW'(1);
               pair_ff  <= 1'b1;
            end
         end
         default: begin
            pair_ff <= pair_ff;
         end
      endcase
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_RESP);
   assign rsp_ok         = ok_ff;
   assign rsp_word_out   = WORD_W'(got_ff[IN_W-1:0]);
   assign rsp_fill_count = FILL_W'(count_ff);

endmodule

>>> hdl/rbil_chk.sv
// rbil_chk: port-level checks for ring_buffer_indexed_list_core, with bind.
// Depends on rbil_pkg and the top level's port list.
module rbil_chk import rbil_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_ok,
   input logic [WORD_W-1:0] rsp_word_out,
   input logic [FILL_W-1:0] rsp_fill_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ok)
         && $stable(rsp_word_out) && $stable(rsp_fill_count))
      else $error("stalled item changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open in the cycle after accept");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_word_out == '0)
      else $error("rejected item carries a word");

   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while an item waits");

endmodule

bind ring_buffer_indexed_list_core rbil_chk u_rbil_chk (.*);
